>>> rtl/cptsgd_pkg.sv
// ----------------------------------------------------------------------------
// cptsgd_pkg
// Shared types, command codes and Q16.16 helpers for the CP tensor SGD block.
// ----------------------------------------------------------------------------
`default_nettype none

package cptsgd_pkg;

   typedef logic signed [31:0] q_type;     // Q16.16 value
   typedef logic signed [32:0] opnd_type;  // multiplier operand
   typedef logic signed [65:0] prod_type;  // full product

   localparam logic [1:0] CMD_TRAIN = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [1:0] MODE_A = 2'd0;
   localparam logic [1:0] MODE_B = 2'd1;
   localparam logic [1:0] MODE_C = 2'd2;

   localparam logic [2:0] CSR_RANK  = 3'd0;
   localparam logic [2:0] CSR_RATE  = 3'd1;
   localparam logic [2:0] CSR_REG_A = 3'd2;
   localparam logic [2:0] CSR_REG_B = 3'd3;
   localparam logic [2:0] CSR_REG_C = 3'd4;

   localparam logic [4:0]  RANK_RESET = 5'd16;
   localparam logic [16:0] RATE_RESET = 17'd655;

   // round half up, floor shift, clamp to 32 bits
   function automatic q_type q_round_sat(input prod_type p);
      prod_type t;
      t = (p + prod_type'(32768)) >>> 16;
      if (t > prod_type'(32'sh7fffffff))
         return q_type'(32'sh7fffffff);
      else if (t < -prod_type'(64'sh80000000))
         return q_type'(32'sh80000000);
      else
         return t[31:0];
   endfunction

   function automatic q_type q_sat33(input logic signed [32:0] s);
      if (s[32] != s[31])
         return s[32] ? q_type'(32'sh80000000) : q_type'(32'sh7fffffff);
      else
         return s[31:0];
   endfunction

   function automatic q_type q_add(input q_type x, input q_type y);
      return q_sat33({x[31], x} + {y[31], y});
   endfunction

   function automatic q_type q_sub(input q_type x, input q_type y);
      return q_sat33({x[31], x} - {y[31], y});
   endfunction

   function automatic opnd_type q_ext(input q_type x);
      return {x[31], x};
   endfunction

   function automatic opnd_type w_ext(input logic [16:0] w);
      return {16'd0, w};
   endfunction

endpackage

`default_nettype wire

>>> rtl/cptsgd_ram.sv
// ----------------------------------------------------------------------------
// cptsgd_ram
// One factor matrix: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cptsgd_ram
   import cptsgd_pkg::*;
#(
   parameter int DEPTH = 16384,
   parameter int AW    = 14
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire q_type         wdata,
   input  wire logic [AW-1:0] raddr,
   output q_type              rdata
);

   q_type mem [DEPTH];
   q_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> rtl/cptsgd_qmul.sv
// ----------------------------------------------------------------------------
// cptsgd_qmul
// Shared Q16.16 multiplier: registered product, then round and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module cptsgd_qmul
   import cptsgd_pkg::*;
(
   input  wire logic     clock,
   input  wire opnd_type op_x,
   input  wire opnd_type op_y,
   output q_type         q
);

   prod_type prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_type'(op_x) * prod_type'(op_y);
   end

   assign q = q_round_sat(prod_ff);

endmodule

`default_nettype wire

>>> rtl/cp_tensor_sgd_update_3mode_top.sv
// ----------------------------------------------------------------------------
// cp_tensor_sgd_update_3mode_top
// Rank-R CP tensor completion, one SGD step per train beat, three modes.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  req_    | in        | req_valid/req_stall  | cmd, mode, row, column, idx, obs
//  rsp_    | out       | rsp_valid/rsp_stall  | residual, read_value
//  csr_    | in        | csr_valid/csr_ready  | csr_index, csr_data
//
//  A train beat runs a prediction pass and then an update pass over
//  n = min(rank_used, RANK) columns on the single shared multiplier, which
//  registers each product and then rounds it (eleven products per column in
//  the update pass, two in the prediction pass).
//  Reset initialises control and configuration; factor memories keep content.
//  A finished result waits in the output register while the next beat is
//  taken; req_stall is high whenever a beat is in progress, and the done
//  state also waits while the old result is still held by rsp_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module cp_tensor_sgd_update_3mode_top
   import cptsgd_pkg::*;
#(
   parameter int RANK   = 16,
   parameter int ROWS_A = 1024,
   parameter int ROWS_B = 1024,
   parameter int ROWS_C = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [1:0]  req_factor_mode,
   input  wire logic [9:0]  req_row_index,
   input  wire logic [3:0]  req_column_index,
   input  wire logic [9:0]  req_idx_a,
   input  wire logic [9:0]  req_idx_b,
   input  wire logic [9:0]  req_idx_c,
   input  wire q_type       req_obs_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output q_type            rsp_residual,
   output q_type            rsp_read_value,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [16:0] csr_data
);

   localparam int DEPTH_A = ROWS_A * RANK;
   localparam int DEPTH_B = ROWS_B * RANK;
   localparam int DEPTH_C = ROWS_C * RANK;
   localparam int AWA = (DEPTH_A > 1) ? $clog2(DEPTH_A) : 1;
   localparam int AWB = (DEPTH_B > 1) ? $clog2(DEPTH_B) : 1;
   localparam int AWC = (DEPTH_C > 1) ? $clog2(DEPTH_C) : 1;
   localparam int CW  = $clog2(RANK + 1);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_LD   = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_RND  = 3'd4;
   localparam logic [2:0] S_LOSS = 3'd5;
   localparam logic [2:0] S_WR   = 3'd6;
   localparam logic [2:0] S_DONE = 3'd7;

   // product steps; prediction pass uses OP_0 and OP_1 only
   localparam logic [3:0] OP_0  = 4'd0;   // pred: a*b     upd: loss*b
   localparam logic [3:0] OP_1  = 4'd1;   // pred: t*c     upd: t*c
   localparam logic [3:0] OP_2  = 4'd2;   // reg_a*a  -> ga
   localparam logic [3:0] OP_3  = 4'd3;   // rate*ga  -> a'
   localparam logic [3:0] OP_4  = 4'd4;   // loss*a
   localparam logic [3:0] OP_5  = 4'd5;   // la*c
   localparam logic [3:0] OP_6  = 4'd6;   // reg_b*b  -> gb
   localparam logic [3:0] OP_7  = 4'd7;   // rate*gb  -> b'
   localparam logic [3:0] OP_8  = 4'd8;   // la*b
   localparam logic [3:0] OP_9  = 4'd9;   // reg_c*c  -> gc
   localparam logic [3:0] OP_10 = 4'd10;  // rate*gc  -> c'

   // configuration
   logic [4:0]  rank_ff;
   logic [16:0] rate_ff, rega_ff, regb_ff, regc_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= RANK_RESET;
         rate_ff <= RATE_RESET;
         rega_ff <= '0;
         regb_ff <= '0;
         regc_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RANK:  rank_ff <= csr_data[4:0];
            CSR_RATE:  rate_ff <= csr_data;
            CSR_REG_A: rega_ff <= csr_data;
            CSR_REG_B: regb_ff <= csr_data;
            CSR_REG_C: regc_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic [CW-1:0] nf;
   assign nf = (32'(rank_ff) > RANK) ? CW'(RANK) : CW'(rank_ff);

   // control state
   logic [2:0]    state_ff, state_in;
   logic [3:0]    op_ff, op_in;
   logic          upd_ff, upd_in;      // 0 prediction pass, 1 update pass
   logic [CW-1:0] f_ff, f_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [1:0] mode_ff;
   logic [9:0] ia_ff, ib_ff, ic_ff;
   q_type      val_ff, a_ff, b_ff, c_ff, t_ff, la_ff, g_ff, pred_ff, loss_ff;
   q_type      an_ff, bn_ff;
   q_type      res_loss_ff, res_read_ff, rsp_res_ff, rsp_read_ff;
   logic       is_read_ff;

   logic accept;
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // request decode
   logic col_ok, elem_ok, rows_ok;
   always_comb begin
      col_ok = 32'(req_column_index) < RANK;
      case (req_factor_mode)
         MODE_A:  elem_ok = col_ok && (32'(req_row_index) < ROWS_A);
         MODE_B:  elem_ok = col_ok && (32'(req_row_index) < ROWS_B);
         MODE_C:  elem_ok = col_ok && (32'(req_row_index) < ROWS_C);
         default: elem_ok = 1'b0;
      endcase
      rows_ok = (32'(req_idx_a) < ROWS_A) && (32'(req_idx_b) < ROWS_B) &&
                (32'(req_idx_c) < ROWS_C);
   end

   // memories
   logic [AWA-1:0] raddr_a, eaddr_a, taddr_a;
   logic [AWB-1:0] raddr_b, eaddr_b, taddr_b;
   logic [AWC-1:0] raddr_c, eaddr_c, taddr_c;
   logic           we_a, we_b, we_c;
   q_type          wdata_a, wdata_b, wdata_c, rdata_a, rdata_b, rdata_c;
   logic           wr_elem;

   assign eaddr_a = AWA'(req_row_index) * AWA'(RANK) + AWA'(req_column_index);
   assign eaddr_b = AWB'(req_row_index) * AWB'(RANK) + AWB'(req_column_index);
   assign eaddr_c = AWC'(req_row_index) * AWC'(RANK) + AWC'(req_column_index);
   assign taddr_a = AWA'(ia_ff) * AWA'(RANK) + AWA'(f_ff);
   assign taddr_b = AWB'(ib_ff) * AWB'(RANK) + AWB'(f_ff);
   assign taddr_c = AWC'(ic_ff) * AWC'(RANK) + AWC'(f_ff);

   assign wr_elem = accept && (req_cmd == CMD_WRITE) && elem_ok;

   always_comb begin
      raddr_a = (state_ff == S_IDLE) ? eaddr_a : taddr_a;
      raddr_b = (state_ff == S_IDLE) ? eaddr_b : taddr_b;
      raddr_c = (state_ff == S_IDLE) ? eaddr_c : taddr_c;
      we_a    = (state_ff == S_WR) || (wr_elem && (req_factor_mode == MODE_A));
      we_b    = (state_ff == S_WR) || (wr_elem && (req_factor_mode == MODE_B));
      we_c    = (state_ff == S_WR) || (wr_elem && (req_factor_mode == MODE_C));
      wdata_a = (state_ff == S_WR) ? an_ff : req_obs_value;
      wdata_b = (state_ff == S_WR) ? bn_ff : req_obs_value;
      wdata_c = (state_ff == S_WR) ? g_ff  : req_obs_value;   // c' parked in g
   end

   cptsgd_ram #(.DEPTH(DEPTH_A), .AW(AWA)) u_ram_a (
      .clock(clock), .we(we_a),
      .waddr((state_ff == S_WR) ? taddr_a : eaddr_a),
      .wdata(wdata_a), .raddr(raddr_a), .rdata(rdata_a));
   cptsgd_ram #(.DEPTH(DEPTH_B), .AW(AWB)) u_ram_b (
      .clock(clock), .we(we_b),
      .waddr((state_ff == S_WR) ? taddr_b : eaddr_b),
      .wdata(wdata_b), .raddr(raddr_b), .rdata(rdata_b));
   cptsgd_ram #(.DEPTH(DEPTH_C), .AW(AWC)) u_ram_c (
      .clock(clock), .we(we_c),
      .waddr((state_ff == S_WR) ? taddr_c : eaddr_c),
      .wdata(wdata_c), .raddr(raddr_c), .rdata(rdata_c));

   // shared multiplier: operands per step
   opnd_type op_x, op_y;
   q_type    q;

   always_comb begin
      op_x = q_ext(a_ff);
      op_y = q_ext(b_ff);
      case (op_ff)
         OP_0:  begin
            op_x = upd_ff ? q_ext(loss_ff) : q_ext(a_ff);
            op_y = q_ext(b_ff);
         end
         OP_1:  begin op_x = q_ext(t_ff);  op_y = q_ext(c_ff); end
         OP_2:  begin op_x = w_ext(rega_ff); op_y = q_ext(a_ff); end
         OP_3:  begin op_x = w_ext(rate_ff); op_y = q_ext(g_ff); end
         OP_4:  begin op_x = q_ext(loss_ff); op_y = q_ext(a_ff); end
         OP_5:  begin op_x = q_ext(la_ff); op_y = q_ext(c_ff); end
         OP_6:  begin op_x = w_ext(regb_ff); op_y = q_ext(b_ff); end
         OP_7:  begin op_x = w_ext(rate_ff); op_y = q_ext(g_ff); end
         OP_8:  begin op_x = q_ext(la_ff); op_y = q_ext(b_ff); end
         OP_9:  begin op_x = w_ext(regc_ff); op_y = q_ext(c_ff); end
         OP_10: begin op_x = w_ext(rate_ff); op_y = q_ext(g_ff); end
         default: ;
      endcase
   end

   cptsgd_qmul u_qmul (.clock(clock), .op_x(op_x), .op_y(op_y), .q(q));

   // sequencer
   logic last_col;
   assign last_col = (f_ff == nf - CW'(1));

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      upd_in   = upd_ff;
      f_in     = f_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               f_in   = '0;
               upd_in = 1'b0;
               if (req_cmd == CMD_TRAIN && rows_ok && nf != '0)
                  state_in = S_RD;
               else if (req_cmd == CMD_TRAIN && rows_ok)
                  state_in = S_LOSS;      // no active column
               else if (req_cmd == CMD_READ && elem_ok)
                  state_in = S_LD;        // element data lands next cycle
               else
                  state_in = S_DONE;
            end
         end
         S_RD: state_in = S_LD;
         S_LD: begin
            op_in    = OP_0;
            state_in = is_read_ff ? S_DONE : S_MUL;
         end
         S_MUL: state_in = S_RND;
         S_RND: begin
            if (!upd_ff && op_ff == OP_1) begin
               if (last_col) begin
                  state_in = S_LOSS;
               end else begin
                  f_in     = f_ff + CW'(1);
                  state_in = S_RD;
               end
            end else if (upd_ff && op_ff == OP_10) begin
               state_in = S_WR;
            end else begin
               op_in    = op_ff + 4'd1;
               state_in = S_MUL;
            end
         end
         S_LOSS: begin
            f_in   = '0;
            upd_in = 1'b1;
            state_in = (nf != '0) ? S_RD : S_DONE;
         end
         S_WR: begin
            if (last_col) begin
               state_in = S_DONE;
            end else begin
               f_in     = f_ff + CW'(1);
               state_in = S_RD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall)
               state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall)
         rsp_valid_in = 1'b0;
      if (state_ff == S_DONE && (!rsp_valid_ff || !rsp_stall))
         rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_0;
         upd_ff       <= 1'b0;
         f_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         upd_ff       <= upd_in;
         f_ff         <= f_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_ff     <= req_factor_mode;
               ia_ff       <= req_idx_a;
               ib_ff       <= req_idx_b;
               ic_ff       <= req_idx_c;
               val_ff      <= req_obs_value;
               pred_ff     <= '0;
               res_loss_ff <= '0;
               res_read_ff <= '0;
               is_read_ff  <= (req_cmd == CMD_READ);
            end
         end
         S_LD: begin
            if (is_read_ff) begin
               case (mode_ff)
                  MODE_A:  res_read_ff <= rdata_a;
                  MODE_B:  res_read_ff <= rdata_b;
                  default: res_read_ff <= rdata_c;
               endcase
            end else begin
               a_ff <= rdata_a;
               b_ff <= rdata_b;
               c_ff <= rdata_c;
            end
         end
         S_RND: begin
            case (op_ff)
               OP_0:  t_ff <= q;
               OP_1: begin
                  if (upd_ff) t_ff    <= q;
                  else        pred_ff <= q_add(pred_ff, q);
               end
               OP_2:  g_ff  <= q_sub(t_ff, q);
               OP_3:  an_ff <= q_add(a_ff, q);
               OP_4:  la_ff <= q;
               OP_5:  t_ff  <= q;
               OP_6:  g_ff  <= q_sub(t_ff, q);
               OP_7:  bn_ff <= q_add(b_ff, q);
               OP_8:  t_ff  <= q;
               OP_9:  g_ff  <= q_sub(t_ff, q);
               OP_10: g_ff  <= q_add(c_ff, q);
               default: ;
            endcase
         end
         S_LOSS: begin
            loss_ff     <= q_sub(val_ff, pred_ff);
            res_loss_ff <= q_sub(val_ff, pred_ff);
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_res_ff  <= res_loss_ff;
               rsp_read_ff <= res_read_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_residual   = rsp_res_ff;
   assign rsp_read_value = rsp_read_ff;

endmodule

`default_nettype wire

>>> rtl/cptsgd_checker.sv
// ----------------------------------------------------------------------------
// cptsgd_checker
// Port-level checks for the CP tensor SGD block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cptsgd_checker
   import cptsgd_pkg::*;
(
   input wire logic  clock,
   input wire logic  reset,
   input wire logic  req_valid,
   input wire logic  req_stall,
   input wire logic  rsp_valid,
   input wire logic  rsp_stall,
   input wire q_type rsp_residual,
   input wire q_type rsp_read_value
);

   // a held result beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_residual) &&
                                    $stable(rsp_read_value)))
      else $error("rsp payload changed while stalled");

   // no result right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // one beat in flight: an accepted request busies the input side
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous beat in flight");

   // a result carries a residual or a read value, never both
   a_one_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_residual == '0 || rsp_read_value == '0))
      else $error("residual and read value both set");

endmodule

bind cp_tensor_sgd_update_3mode_top cptsgd_checker u_cptsgd_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_residual(rsp_residual), .rsp_read_value(rsp_read_value));

`default_nettype wire
